/* src/pct_pkg.sv */
package pct_pkg;

	// Widths of the call identifier and of the handle as they appear on the ports.
	localparam int KEY_W         = 32;
	localparam int HANDLE_PORT_W = 32;

	// Defaults for the top level parameters.
	localparam int TABLE_DEPTH_DEF  = 16;
	localparam int HANDLE_WIDTH_DEF = 32;

	typedef enum logic [1:0] {
		OP_PUT    = 2'd0,
		OP_GET    = 2'd1,
		OP_REMOVE = 2'd2,
		OP_POP    = 2'd3
	} op_e;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_MISS = 2'd1,
		ST_FULL = 2'd2
	} status_e;

	typedef struct packed {
		status_e                    status;
		logic [HANDLE_PORT_W-1:0] handle;
	} result_t;

endpackage

/* src/pct_store.sv */
module pct_store #(
	parameter int TABLE_DEPTH  = pct_pkg::TABLE_DEPTH_DEF,
	parameter int HANDLE_WIDTH = pct_pkg::HANDLE_WIDTH_DEF,
	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
	localparam int HW    = (HANDLE_WIDTH < pct_pkg::HANDLE_PORT_W) ?
	                       HANDLE_WIDTH : pct_pkg::HANDLE_PORT_W
) (
	input  logic                      clk,
	input  logic                      wr_en,
	input  logic [IDX_W-1:0]          wr_addr,
	input  logic [pct_pkg::KEY_W-1:0] wr_key,
	input  logic [HW-1:0]             wr_handle,
	input  logic [IDX_W-1:0]          rd_addr,
	output logic [pct_pkg::KEY_W-1:0] rd_key,
	output logic [HW-1:0]             rd_handle
);

	// Key and handle arrays share one write port and one registered read port.
	logic [pct_pkg::KEY_W-1:0] key_mem    [TABLE_DEPTH];
	logic [HW-1:0]             handle_mem [TABLE_DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			key_mem[wr_addr]    <= wr_key;
			handle_mem[wr_addr] <= wr_handle;
		end
		rd_key    <= key_mem[rd_addr];
		rd_handle <= handle_mem[rd_addr];
	end

endmodule

/* src/pct_seq.sv */
module pct_seq #(
	parameter int TABLE_DEPTH  = pct_pkg::TABLE_DEPTH_DEF,
	parameter int HANDLE_WIDTH = pct_pkg::HANDLE_WIDTH_DEF,
	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1),
	localparam int HW    = (HANDLE_WIDTH < pct_pkg::HANDLE_PORT_W) ?
	                       HANDLE_WIDTH : pct_pkg::HANDLE_PORT_W
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  pct_pkg::op_e                      in_op,
	input  logic [pct_pkg::KEY_W-1:0]         in_key,
	input  logic [pct_pkg::HANDLE_PORT_W-1:0] in_handle,
	output logic                              res_valid,
	input  logic                              res_ready,
	output pct_pkg::result_t                  res,
	output logic [CNT_W-1:0]                  count,
	output logic                              wr_en,
	output logic [IDX_W-1:0]                  wr_addr,
	output logic [pct_pkg::KEY_W-1:0]         wr_key,
	output logic [HW-1:0]                     wr_handle,
	output logic [IDX_W-1:0]                  rd_addr,
	input  logic [pct_pkg::KEY_W-1:0]         rd_key,
	input  logic [HW-1:0]                     rd_handle
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_START,
		S_SCAN,
		S_SHIFT,
		S_DONE
	} state_t;

	state_t                    state_q;
	pct_pkg::op_e              op_q;
	logic [pct_pkg::KEY_W-1:0] key_q;
	logic [HW-1:0]             handle_q;
	logic [CNT_W-1:0]          occ_q;
	logic [CNT_W-1:0]          idx_q;
	logic [IDX_W-1:0]          cmp_idx_q;
	logic                      cmp_vld_q;
	pct_pkg::result_t          res_q;

	logic idx_lt;
	logic match;
	logic full;

	// The single comparator: the entry read last cycle against the searched key.
	// Pop takes the oldest entry, so its first read always matches.
	assign idx_lt = (idx_q < occ_q);
	assign match  = cmp_vld_q && ((op_q == pct_pkg::OP_POP) || (rd_key == key_q));
	assign full   = (occ_q == CNT_W'(TABLE_DEPTH));

	assign rd_addr = idx_q[IDX_W-1:0];

	always_comb begin
		if (state_q == S_START) begin
			wr_en     = (op_q == pct_pkg::OP_PUT) && !full;
			wr_addr   = occ_q[IDX_W-1:0];
			wr_key    = key_q;
			wr_handle = handle_q;
		end else begin
			// During a shift, the entry that just arrived moves down one slot.
			wr_en     = (state_q == S_SHIFT) && cmp_vld_q;
			wr_addr   = cmp_idx_q - 1'b1;
			wr_key    = rd_key;
			wr_handle = rd_handle;
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign res_valid = (state_q == S_DONE);
	assign res       = res_q;
	assign count     = occ_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			occ_q     <= '0;
			idx_q     <= '0;
			cmp_vld_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						op_q      <= in_op;
						key_q     <= in_key;
						handle_q  <= in_handle[HW-1:0];
						idx_q     <= '0;
						cmp_vld_q <= 1'b0;
						state_q   <= S_START;
					end
				end
				S_START: begin
					if (op_q == pct_pkg::OP_PUT) begin
						res_q.handle <= '0;
						if (full) begin
							res_q.status <= pct_pkg::ST_FULL;
						end else begin
							res_q.status <= pct_pkg::ST_OK;
							occ_q        <= occ_q + 1'b1;
						end
						state_q <= S_DONE;
					end else begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (match) begin
						cmp_vld_q    <= 1'b0;
						res_q.status <= pct_pkg::ST_OK;
						if (op_q == pct_pkg::OP_REMOVE) begin
							res_q.handle <= '0;
						end else begin
							res_q.handle <= pct_pkg::HANDLE_PORT_W'(rd_handle);
						end
						// idx_q already points one past the match: the shift starts there.
						state_q <= (op_q == pct_pkg::OP_GET) ? S_DONE : S_SHIFT;
					end else if (idx_lt) begin
						cmp_vld_q <= 1'b1;
						cmp_idx_q <= idx_q[IDX_W-1:0];
						idx_q     <= idx_q + 1'b1;
					end else if (cmp_vld_q) begin
						cmp_vld_q <= 1'b0;
					end else begin
						res_q.status <= pct_pkg::ST_MISS;
						res_q.handle <= '0;
						state_q      <= S_DONE;
					end
				end
				S_SHIFT: begin
					cmp_vld_q <= idx_lt;
					if (idx_lt) begin
						cmp_idx_q <= idx_q[IDX_W-1:0];
						idx_q     <= idx_q + 1'b1;
					end else if (!cmp_vld_q) begin
						occ_q   <= occ_q - 1'b1;
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

/* src/pending_call_table.sv */
// Pending call table: an ordered table of outstanding calls, oldest first, each entry
// pairing a 32-bit call identifier with a call handle. The operation code arrives in
// s_axis_tuser (put, get by identifier, remove by identifier, pop oldest) and every
// word in yields exactly one result word with a status, a handle and the entry count
// after the operation. The table sits in a memory with one write port and one
// registered read port, and a small sequencer walks it one entry per cycle with a
// single comparator. A get or remove acts on the oldest entry with a matching
// identifier. A remove or a pop that hits also moves every younger entry down one
// slot, one entry per cycle through the same read port, once the search ends. The
// block takes one word at a time and is ready again as soon as its result is loaded
// into the output register; the result waits there, so the next word is taken while
// the last result is unread. Reset empties the table at once; the memory itself needs
// no clearing pass, since only entries below the count are ever used.
module pending_call_table #(
	parameter int TABLE_DEPTH  = pct_pkg::TABLE_DEPTH_DEF,
	parameter int HANDLE_WIDTH = pct_pkg::HANDLE_WIDTH_DEF,
	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1),
	localparam int HW    = (HANDLE_WIDTH < pct_pkg::HANDLE_PORT_W) ?
	                       HANDLE_WIDTH : pct_pkg::HANDLE_PORT_W,
	localparam int IN_W  = ((pct_pkg::KEY_W + pct_pkg::HANDLE_PORT_W + 7) / 8) * 8,
	localparam int OUT_W = ((pct_pkg::HANDLE_PORT_W + CNT_W + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	// Fields from bit 0 up: call_key (32), call_handle (32).
	input  logic [IN_W-1:0]  s_axis_tdata,
	// Fields from bit 0 up: operation (2).
	input  logic [1:0]       s_axis_tuser,
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	// Fields from bit 0 up: handle_out (32), entry_count (CNT_W), zero padding.
	output logic [OUT_W-1:0] m_axis_tdata,
	// Fields from bit 0 up: status (2).
	output logic [1:0]       m_axis_tuser
);

	logic                              res_valid;
	logic                              res_ready;
	pct_pkg::result_t                  res;
	logic [CNT_W-1:0]                  count;
	logic                              wr_en;
	logic [IDX_W-1:0]                  wr_addr;
	logic [pct_pkg::KEY_W-1:0]         wr_key;
	logic [HW-1:0]                     wr_handle;
	logic [IDX_W-1:0]                  rd_addr;
	logic [pct_pkg::KEY_W-1:0]         rd_key;
	logic [HW-1:0]                     rd_handle;

	// Output register: holds one finished result until the sink takes it.
	logic                              out_vld_q;
	pct_pkg::result_t                  out_res_q;
	logic [CNT_W-1:0]                  out_count_q;

	pct_seq #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.HANDLE_WIDTH(HANDLE_WIDTH)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_op    (pct_pkg::op_e'(s_axis_tuser)),
		.in_key   (s_axis_tdata[pct_pkg::KEY_W-1:0]),
		.in_handle(s_axis_tdata[pct_pkg::KEY_W +: pct_pkg::HANDLE_PORT_W]),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res),
		.count    (count),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_key   (wr_key),
		.wr_handle(wr_handle),
		.rd_addr  (rd_addr),
		.rd_key   (rd_key),
		.rd_handle(rd_handle)
	);

	pct_store #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.HANDLE_WIDTH(HANDLE_WIDTH)
	) u_store (
		.clk      (clk),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_key   (wr_key),
		.wr_handle(wr_handle),
		.rd_addr  (rd_addr),
		.rd_key   (rd_key),
		.rd_handle(rd_handle)
	);

	// The register takes a new result when it is empty or its word leaves this cycle.
	assign res_ready = !out_vld_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else begin
			if (res_valid && res_ready) begin
				out_vld_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_res_q   <= res;
			out_count_q <= count;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tuser  = out_res_q.status;
	assign m_axis_tdata  = OUT_W'({out_count_q, out_res_q.handle});

	// The sequencer never offers a result while it is taking a new word.
	a_ready_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_axis_tready && res_valid))
		else $error("sequencer ready while a result is pending");

	// The reported count never exceeds the table depth.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (out_count_q <= CNT_W'(TABLE_DEPTH)))
		else $error("entry count beyond table depth");

	// A full status is only reported with the table full.
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (out_res_q.status == pct_pkg::ST_FULL))
		|-> (out_count_q == CNT_W'(TABLE_DEPTH)))
		else $error("full status with a table that is not full");

	// A result that is not ok carries a zero handle.
	a_miss_handle: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (out_res_q.status != pct_pkg::ST_OK))
		|-> (out_res_q.handle == '0))
		else $error("nonzero handle on a failed operation");

endmodule

/* verif/pending_call_table_test.sv */
`timescale 1ns / 1ps
module pending_call_table_test;

	localparam int DEPTH           = pct_pkg::TABLE_DEPTH_DEF;
	localparam int KW              = pct_pkg::KEY_W;
	localparam int HPW             = pct_pkg::HANDLE_PORT_W;
	localparam int CNT_W           = $clog2(DEPTH + 1);
	localparam int IN_W            = ((KW + HPW + 7) / 8) * 8;
	localparam int OUT_W           = ((HPW + CNT_W + 7) / 8) * 8;
	localparam int RANDOM_PER_PASS = 220;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int SETTLE_CYCLES   = 64;
	localparam int CYCLE_LIMIT     = 400000;

	typedef struct {
		pct_pkg::status_e status;
		logic [HPW-1:0]   handle;
		logic [CNT_W-1:0] count;
	} call_result_t;

	// Keeps its own copy of the call table, oldest entry at index zero, and the
	// results still owed by the block in the order the words went in.
	class call_table_scoreboard;
		logic [KW-1:0]  keys [DEPTH];
		logic [HPW-1:0] handles [DEPTH];
		int unsigned    held;
		call_result_t   owed [$];
		int unsigned    mismatches;

		function new();
			held = 0;
			mismatches = 0;
		endfunction

		function int oldest_match(logic [KW-1:0] key);
			for (int i = 0; i < held; i++)
				if (keys[i] == key)
					return i;
			return -1;
		endfunction

		// Deletes one entry and slides the younger ones down over it.
		function void drop_entry(int idx);
			for (int i = idx; i + 1 < held; i++) begin
				keys[i] = keys[i + 1];
				handles[i] = handles[i + 1];
			end
			held--;
			keys[held] = '0;
			handles[held] = '0;
		endfunction

		function void note_word(pct_pkg::op_e op, logic [KW-1:0] key,
		                        logic [HPW-1:0] handle);
			call_result_t r;
			int idx;
			r.status = pct_pkg::ST_MISS;
			r.handle = '0;
			case (op)
				pct_pkg::OP_PUT: begin
					if (held >= DEPTH) begin
						r.status = pct_pkg::ST_FULL;
					end else begin
						keys[held] = key;
						handles[held] = handle;
						held++;
						r.status = pct_pkg::ST_OK;
					end
				end
				pct_pkg::OP_GET: begin
					idx = oldest_match(key);
					if (idx >= 0) begin
						r.handle = handles[idx];
						r.status = pct_pkg::ST_OK;
					end
				end
				pct_pkg::OP_REMOVE: begin
					idx = oldest_match(key);
					if (idx >= 0) begin
						drop_entry(idx);
						r.status = pct_pkg::ST_OK;
					end
				end
				default: begin
					if (held > 0) begin
						r.handle = handles[0];
						drop_entry(0);
						r.status = pct_pkg::ST_OK;
					end
				end
			endcase
			r.count = CNT_W'(held);
			owed.push_back(r);
		endfunction

		function void note_mismatch(string what);
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch: %s", what);
		endfunction

		function void check_result(call_result_t got);
			call_result_t want;
			if (owed.size() == 0) begin
				note_mismatch($sformatf(
					"result word with none owed: status %0d handle %h count %0d",
					got.status, got.handle, got.count));
				return;
			end
			want = owed.pop_front();
			if (want.status !== got.status || want.handle !== got.handle ||
			    want.count !== got.count)
				note_mismatch($sformatf(
					"expected status %0d handle %h count %0d, got status %0d handle %h count %0d",
					want.status, want.handle, want.count,
					got.status, got.handle, got.count));
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n;
	logic              s_valid;
	logic              s_ready;
	logic [IN_W-1:0]   s_data;
	logic [1:0]        s_op;
	logic              m_valid;
	logic              m_ready = 1'b0;
	logic [OUT_W-1:0]  m_data;
	logic [1:0]        m_status;

	call_table_scoreboard board;
	logic [KW-1:0]        key_pool [8];
	int                   sender_idle_pct;
	int                   stall_pct;
	logic                 hold_req;
	logic                 hold_ack = 1'b0;
	int                   hold_left = 0;
	int                   cycle_count;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	pending_call_table i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_valid),
		.s_axis_tready (s_ready),
		.s_axis_tdata  (s_data),
		.s_axis_tuser  (s_op),
		.m_axis_tvalid (m_valid),
		.m_axis_tready (m_ready),
		.m_axis_tdata  (m_data),
		.m_axis_tuser  (m_status)
	);

	// Result side: check every accepted word, then decide on next cycle's ready.
	// A toggle of hold_req starts one long hold-off that this process counts down.
	always @(posedge clk) begin
		call_result_t got;
		if (arst_n === 1'b1 && m_valid && m_ready) begin
			got.status = pct_pkg::status_e'(m_status);
			got.handle = m_data[HPW-1:0];
			got.count = m_data[HPW +: CNT_W];
			board.check_result(got);
		end
		if (hold_req != hold_ack) begin
			hold_ack <= hold_req;
			hold_left <= HOLD_OFF_CYCLES;
			m_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_ready <= 1'b0;
		end else begin
			m_ready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("simulation failed");
		$finish;
	end

	// Offers one word, idling first at the sender's current rate, and records it
	// with the scoreboard once the block has taken it.
	task automatic send_word(pct_pkg::op_e op, logic [KW-1:0] key,
	                         logic [HPW-1:0] handle);
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			s_valid <= 1'b0;
			@(posedge clk);
		end
		s_valid <= 1'b1;
		s_data <= {handle, key};
		s_op <= op;
		do
			@(posedge clk);
		while (!s_ready);
		board.note_word(op, key, handle);
	endtask

	function automatic pct_pkg::op_e pick_op(int put_pct);
		int r;
		r = $urandom_range(0, 99);
		if (r < put_pct)
			return pct_pkg::OP_PUT;
		r = $urandom_range(0, 99);
		if (r < 40)
			return pct_pkg::OP_GET;
		if (r < 75)
			return pct_pkg::OP_REMOVE;
		return pct_pkg::OP_POP;
	endfunction

	// Keys mostly come from a small pool so that lookups hit and duplicates pile up.
	function automatic logic [KW-1:0] pick_key();
		if ($urandom_range(0, 9) == 0)
			return $urandom;
		return key_pool[$urandom_range(0, 7)];
	endfunction

	function automatic logic [HPW-1:0] pick_handle();
		case ($urandom_range(0, 19))
			0: return '0;
			1: return '1;
			default: return $urandom;
		endcase
	endfunction

	initial begin
		int put_pct;
		board = new();
		arst_n <= 1'b0;
		s_valid <= 1'b0;
		s_data <= '0;
		s_op <= pct_pkg::OP_PUT;
		hold_req <= 1'b0;
		sender_idle_pct = 0;
		stall_pct = 0;
		key_pool[0] = '0;
		key_pool[1] = '1;
		for (int i = 2; i < 8; i++)
			key_pool[i] = $urandom;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty table: every lookup and pop misses.
		send_word(pct_pkg::OP_POP, '0, '0);
		send_word(pct_pkg::OP_GET, '0, '0);
		send_word(pct_pkg::OP_REMOVE, '1, '0);
		// Extreme keys and handles, and a duplicate key behind the first.
		send_word(pct_pkg::OP_PUT, '0, '1);
		send_word(pct_pkg::OP_PUT, '1, '0);
		send_word(pct_pkg::OP_PUT, '0, 32'h0000_0001);
		send_word(pct_pkg::OP_GET, '0, '0);
		send_word(pct_pkg::OP_GET, '1, '0);
		send_word(pct_pkg::OP_GET, 32'h5a5a_a5a5, '0);
		send_word(pct_pkg::OP_REMOVE, 32'h5a5a_a5a5, '0);
		// Removing the oldest duplicate leaves the younger one for the next get.
		send_word(pct_pkg::OP_REMOVE, '0, '0);
		send_word(pct_pkg::OP_GET, '0, '0);
		// Fill up, try one put too many, then pop from the full table.
		for (int i = 0; i < DEPTH - 2; i++)
			send_word(pct_pkg::OP_PUT, key_pool[i % 8], pick_handle());
		send_word(pct_pkg::OP_PUT, key_pool[3], '1);
		send_word(pct_pkg::OP_POP, '0, '0);
		send_word(pct_pkg::OP_POP, '0, '0);

		// Random passes, one per idling pattern. The mix swings between filling,
		// balanced and draining every fifty words so that both ends are reached.
		for (int pass = 0; pass < 4; pass++) begin
			case (pass)
				0: begin sender_idle_pct = 0;  stall_pct = 0;  end
				1: begin sender_idle_pct = 48; stall_pct = 0;  end
				2: begin sender_idle_pct = 0;  stall_pct = 48; end
				default: begin sender_idle_pct = 19; stall_pct = 19; end
			endcase
			for (int n = 0; n < RANDOM_PER_PASS; n++) begin
				if (pass == 0 && n == RANDOM_PER_PASS / 2)
					hold_req <= ~hold_req;
				case ((n / 50) % 3)
					0: put_pct = 70;
					1: put_pct = 45;
					default: put_pct = 15;
				endcase
				send_word(pick_op(put_pct), pick_key(), pick_handle());
			end
		end
		s_valid <= 1'b0;
		stall_pct = 0;

		while (board.owed.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (board.mismatches == 0 && board.owed.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
